FILE: design/gohsv_pkg.sv
// Shared types, register indexes and helpers for the gradient orientation block.
// No dependencies; imported by gradient_orientation_hsv.
package gohsv_pkg;

   localparam int MAX_WIDTH = 1024;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [7:0]  hue;
      logic [7:0]  strength;
      logic [9:0]  pos_x;
      logic [11:0] pos_y;
      logic        frame_done;
   } rsp_type;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_VALUE_GAIN   = 2'd2;

   localparam int DIV_STEPS = 18;

   function automatic logic [9:0] absdiff_sum(input logic [23:0] a, input logic [23:0] b);
      logic [9:0] s;
      logic [7:0] ca;
      logic [7:0] cb;
      s = '0;
      for (int i = 0; i < 3; i++) begin
         ca = a[i*8 +: 8];
         cb = b[i*8 +: 8];
         s = s + ((ca > cb) ? 10'(ca - cb) : 10'(cb - ca));
      end
      return s;
   endfunction

endpackage

FILE: design/gradient_orientation_hsv.sv
// Gradient orientation map: RGB raster in, hue and strength per interior pixel out.
// Uses gohsv_pkg for payload types, register indexes and the difference sum.
//
// Usage: pixels enter in raster order on the req_ channel (valid/ready); frame_start
// places a pixel at column 0, row 0. Two line memories, one per row parity, hold the
// previous rows; a 3x3 window forms the neighbourhood. For each interior pixel one
// transfer leaves on the rsp_ channel with hue, strength, centre position and a
// frame_done flag on the last interior pixel. Border pixels give no transfer.
// Steps: a border pixel has a line memory read and a window shift. An interior pixel
// has memory read, window shift, difference sums, branch selection, gain multiply,
// then an 18-step restoring divider, one quotient bit per cycle; then the result
// register loads and the block returns to idle. A flat neighbourhood skips the
// divider. No new pixel is taken until the block is back in idle.
// The result register parts the channels: a stalled receiver holds the result while
// the next pixels are read in; only a finished result waiting behind a full result
// register holds the input.
// Reset (synchronous): counters at zero, registers at 640 x 480 and gain 1.0, no
// result pending. Line memories are not cleared. Write csr_ registers while idle.
module gradient_orientation_hsv
   import gohsv_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int XW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam int EW = ($clog2(MAX_WIDTH + 1) > 11) ? $clog2(MAX_WIDTH + 1) : 11;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_READ  = 3'd1;
   localparam logic [2:0] S_SUM   = 3'd2;
   localparam logic [2:0] S_PREP  = 3'd3;
   localparam logic [2:0] S_SCALE = 3'd4;
   localparam logic [2:0] S_DIV   = 3'd5;
   localparam logic [2:0] S_OUT   = 3'd6;

   logic [2:0]  state_ff, state_in;
   logic [10:0] width_ff;
   logic [12:0] height_ff;
   logic [15:0] gain_ff;
   logic [XW-1:0] col_ff, col_in;
   logic [11:0] row_ff, row_in;

   logic [23:0] mem0 [MAX_WIDTH];
   logic [23:0] mem1 [MAX_WIDTH];
   logic [23:0] rd0_ff, rd1_ff;
   logic [23:0] pix_ff;
   logic        slot_ff;
   logic        emit_ff;
   logic        done_ff;
   logic [9:0]  posx_ff;
   logic [11:0] posy_ff;
   logic [23:0] win_ff [9];

   logic signed [10:0] j_ff, h_ff;
   logic [17:0] nmag_ff;
   logic [9:0]  dmag_ff;
   logic        qneg_ff;
   logic        zero_ff;
   logic [7:0]  v_ff;
   logic [7:0]  str_ff;
   logic [10:0] rem_ff;
   logic [17:0] quo_ff;
   logic [4:0]  cnt_ff;

   logic        rsp_valid_ff;
   rsp_type     rsp_ff;

   logic          accept;
   logic [EW-1:0] wid_eff;
   logic [12:0]   hei_eff;
   logic [XW-1:0] x_cur;
   logic [11:0]   y_cur;
   logic [EW-1:0] x_ext;
   logic [12:0]   y_ext;
   logic [EW-1:0] x_nxt;
   logic [12:0]   y_nxt;
   logic          emit_cur;
   logic          done_cur;
   logic [23:0]   top_w, mid_w;

   logic [9:0]  aj, ah;
   logic [7:0]  tj, th;
   logic [19:0] tj_p, th_p;
   logic        sel_h;
   logic signed [19:0] num;
   logic signed [10:0] den;
   logic [19:0] nabs;
   logic [10:0] dabs;
   logic [23:0] prod;
   logic [10:0] trial;
   logic [7:0]  hue_w;
   logic        load_rsp;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      if (EW'(width_ff) < EW'(3)) wid_eff = EW'(3);
      else if (EW'(width_ff) > EW'(MAX_WIDTH)) wid_eff = EW'(MAX_WIDTH);
      else wid_eff = EW'(width_ff);
      if (height_ff < 13'd3) hei_eff = 13'd3;
      else if (height_ff > 13'd4096) hei_eff = 13'd4096;
      else hei_eff = height_ff;
   end

   always_comb begin
      x_cur    = req_data.frame_start ? '0 : col_ff;
      y_cur    = req_data.frame_start ? '0 : row_ff;
      x_ext    = EW'(x_cur);
      y_ext    = 13'(y_cur);
      emit_cur = (x_ext >= EW'(2)) && (y_ext >= 13'd2) && (x_ext < wid_eff) &&
                 (y_ext < hei_eff);
      done_cur = (x_ext == wid_eff - EW'(1)) && (y_ext == hei_eff - 13'd1);
      x_nxt    = x_ext + EW'(1);
      y_nxt    = y_ext;
      col_in   = XW'(x_nxt);
      row_in   = y_cur;
      if (x_nxt >= wid_eff) begin
         col_in = '0;
         y_nxt  = y_ext + 13'd1;
         row_in = (y_nxt >= hei_eff) ? 12'd0 : y_nxt[11:0];
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rd0_ff <= mem0[x_cur];
         rd1_ff <= mem1[x_cur];
         if (!y_cur[0]) mem0[x_cur] <= {req_data.red, req_data.green, req_data.blue};
         else mem1[x_cur] <= {req_data.red, req_data.green, req_data.blue};
      end
   end

   always_comb begin
      top_w = slot_ff ? rd1_ff : rd0_ff;
      mid_w = slot_ff ? rd0_ff : rd1_ff;
   end

   always_comb begin
      aj   = j_ff[10] ? 10'(-j_ff) : 10'(j_ff);
      ah   = h_ff[10] ? 10'(-h_ff) : 10'(h_ff);
      tj_p = 20'(aj) * 20'd683;
      th_p = 20'(ah) * 20'd683;
      tj   = tj_p[18:11];
      th   = th_p[18:11];
      sel_h = th > tj;
      if (sel_h) begin
         num = 20'(32 * 20'(j_ff)) + (h_ff > 0 ? 20'(192) : 20'(64)) * 20'(h_ff);
         den = h_ff;
      end else begin
         num = -20'(32 * 20'(h_ff)) + (j_ff > 0 ? 20'(256) : 20'(128)) * 20'(j_ff);
         den = j_ff;
      end
      nabs = num[19] ? -num : num;
      dabs = den[10] ? -den : den;
   end

   assign prod  = 24'(v_ff) * 24'(gain_ff);
   assign trial = {rem_ff[9:0], quo_ff[17]};
   assign hue_w = zero_ff ? 8'd0 : (qneg_ff ? quo_ff[7:0] : 8'(-quo_ff[7:0]));
   assign load_rsp = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:  if (accept) state_in = S_READ;
         S_READ:  state_in = emit_ff ? S_SUM : S_IDLE;
         S_SUM:   state_in = S_PREP;
         S_PREP:  state_in = S_SCALE;
         S_SCALE: state_in = zero_ff ? S_OUT : S_DIV;
         S_DIV:   if (cnt_ff == 5'(DIV_STEPS - 1)) state_in = S_OUT;
         S_OUT:   if (load_rsp) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         width_ff     <= 11'd640;
         height_ff    <= 13'd480;
         gain_ff      <= 16'd256;
         col_ff       <= '0;
         row_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[10:0];
               CSR_FRAME_HEIGHT: height_ff <= csr_wdata[12:0];
               CSR_VALUE_GAIN:   gain_ff   <= csr_wdata;
               default: ;
            endcase
         end
         if (accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
         if (load_rsp) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (state_ff == S_SCALE) cnt_ff <= '0;
         else if (state_ff == S_DIV) cnt_ff <= cnt_ff + 5'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pix_ff  <= {req_data.red, req_data.green, req_data.blue};
         slot_ff <= y_cur[0];
         emit_ff <= emit_cur;
         done_ff <= done_cur;
         posx_ff <= 10'(x_cur - XW'(1));
         posy_ff <= y_cur - 12'd1;
      end
      if (state_ff == S_READ) begin
         win_ff[0] <= win_ff[1];
         win_ff[1] <= win_ff[2];
         win_ff[2] <= top_w;
         win_ff[3] <= win_ff[4];
         win_ff[4] <= win_ff[5];
         win_ff[5] <= mid_w;
         win_ff[6] <= win_ff[7];
         win_ff[7] <= win_ff[8];
         win_ff[8] <= pix_ff;
      end
      if (state_ff == S_SUM) begin
         j_ff <= 11'(absdiff_sum(win_ff[5], win_ff[3])) -
                 11'(absdiff_sum(win_ff[7], win_ff[1]));
         h_ff <= 11'(absdiff_sum(win_ff[8], win_ff[0])) -
                 11'(absdiff_sum(win_ff[6], win_ff[2]));
      end
      if (state_ff == S_PREP) begin
         nmag_ff <= nabs[17:0];
         dmag_ff <= dabs[9:0];
         qneg_ff <= num[19] ^ den[10];
         zero_ff <= !sel_h && (j_ff == 11'sd0);
         v_ff    <= sel_h ? th : ((j_ff == 11'sd0) ? 8'd0 : tj);
      end
      if (state_ff == S_SCALE) begin
         str_ff <= (|prod[23:16]) ? 8'd255 : prod[15:8];
         rem_ff <= '0;
         quo_ff <= nmag_ff;
      end
      if (state_ff == S_DIV) begin
         if (trial >= {1'b0, dmag_ff}) begin
            rem_ff <= trial - {1'b0, dmag_ff};
            quo_ff <= {quo_ff[16:0], 1'b1};
         end else begin
            rem_ff <= trial;
            quo_ff <= {quo_ff[16:0], 1'b0};
         end
      end
      if (load_rsp) begin
         rsp_ff.hue        <= hue_w;
         rsp_ff.strength   <= str_ff;
         rsp_ff.pos_x      <= posx_ff;
         rsp_ff.pos_y      <= posy_ff;
         rsp_ff.frame_done <= done_ff;
      end
   end

   a_accept_reads : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_READ)
      else $error("accepted pixel did not start a line memory read");

   a_rsp_from_out : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_OUT)
      else $error("result raised outside the output step");

   a_div_bound : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> cnt_ff < 5'(DIV_STEPS))
      else $error("divider ran past its step count");

   a_zero_strength : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_OUT && zero_ff) |-> str_ff == 8'd0)
      else $error("flat neighbourhood gave non-zero strength");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for gradient_orientation_hsv: raster pixels in, hue and strength out.
// Predicts each transfer from a behavioural copy of the line stores and window.
// Depends on gohsv_pkg and the block's RTL only.
module tb
   import gohsv_pkg::*;
;

   localparam int MAXW = 1024;
   localparam int CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   rsp_type     rsp_data;
   logic        csr_wr_en = 1'b0;
   logic [1:0]  csr_index = CSR_FRAME_WIDTH;
   logic [15:0] csr_wdata = '0;

   gradient_orientation_hsv i_dut (.*);

   always #6 clock = ~clock;

   req_type     pixel_queue[$];
   rsp_type     orient_queue[$];
   int          errors = 0;
   int          tx_idle_pct = 0;
   int          rx_idle_pct = 0;
   logic        stall = 1'b0;
   logic        start_hold = 1'b0;
   longint      cycles = 0;

   // predictor state
   logic [23:0] line_mem[2*MAXW];
   logic [23:0] win[9];
   int          col_cnt = 0;
   int          row_cnt = 0;
   int          cfg_width = 640;
   int          cfg_height = 480;
   int          cfg_gain = 256;

   task automatic report(string what, int got, int exp_val);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, exp_val, $realtime);
      errors++;
   endtask

   function automatic int chan_diff(logic [23:0] a, logic [23:0] b);
      int s;
      int d;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         d = int'(a[i*8 +: 8]) - int'(b[i*8 +: 8]);
         s += (d < 0) ? -d : d;
      end
      return s;
   endfunction

   function automatic int mag(int v);
      return (v < 0) ? -v : v;
   endfunction

   task automatic predict_orientation(req_type p);
      int wid, hei, x, y, slot_old, slot_mid;
      int a, b, c, d, j, h, tj, th, q, v;
      longint str;
      logic [23:0] top, mid, px;
      rsp_type r;
      wid = (cfg_width < 3) ? 3 : (cfg_width > MAXW) ? MAXW : cfg_width;
      hei = (cfg_height < 3) ? 3 : (cfg_height > 4096) ? 4096 : cfg_height;
      px = {p.red, p.green, p.blue};
      if (p.frame_start) begin
         col_cnt = 0;
         row_cnt = 0;
      end
      x = col_cnt;
      y = row_cnt;
      slot_old = y & 1;
      slot_mid = (y + 1) & 1;
      top = line_mem[slot_old*MAXW + x];
      mid = line_mem[slot_mid*MAXW + x];
      line_mem[slot_old*MAXW + x] = px;
      for (int i = 0; i < 3; i++) begin
         win[i*3] = win[i*3+1];
         win[i*3+1] = win[i*3+2];
      end
      win[2] = top;
      win[5] = mid;
      win[8] = px;
      if (x >= 2 && y >= 2 && x < wid && y < hei) begin
         a = chan_diff(win[5], win[3]);
         b = chan_diff(win[8], win[0]);
         c = chan_diff(win[7], win[1]);
         d = chan_diff(win[6], win[2]);
         j = a - c;
         h = b - d;
         tj = j / 3;
         th = h / 3;
         q = 0;
         v = 0;
         r = '0;
         if (mag(th) > mag(tj)) begin
            if (h != 0) begin
               q = (32*j + (((h > 0) ? 128 : 0) + 64)*h) / h;
               v = mag(th);
               r.hue = 8'(-q);
            end
         end else if (j != 0) begin
            q = (-32*h + (((j > 0) ? 128 : 0) + 128)*j) / j;
            v = mag(tj);
            r.hue = 8'(-q);
         end
         str = (longint'(v) * cfg_gain) >>> 8;
         r.strength = (str > 255) ? 8'd255 : 8'(str);
         r.pos_x = 10'(x - 1);
         r.pos_y = 12'(y - 1);
         r.frame_done = (x == wid - 1 && y == hei - 1);
         orient_queue.push_back(r);
      end
      x++;
      if (x >= wid) begin
         x = 0;
         y++;
         if (y >= hei) y = 0;
      end
      col_cnt = x;
      row_cnt = y;
   endtask

   // driver
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) predict_orientation(req_data);
         if (!req_valid || req_ready) begin
            if (pixel_queue.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
               req_data <= pixel_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (orient_queue.size() == 0) begin
               report("unexpected transfer pos_x", rsp_data.pos_x, -1);
            end else begin
               rsp_type e;
               e = orient_queue.pop_front();
               if (rsp_data.hue !== e.hue) report("hue", rsp_data.hue, e.hue);
               if (rsp_data.strength !== e.strength)
                  report("strength", rsp_data.strength, e.strength);
               if (rsp_data.pos_x !== e.pos_x) report("pos_x", rsp_data.pos_x, e.pos_x);
               if (rsp_data.pos_y !== e.pos_y) report("pos_y", rsp_data.pos_y, e.pos_y);
               if (rsp_data.frame_done !== e.frame_done)
                  report("frame_done", rsp_data.frame_done, e.frame_done);
            end
         end
         rsp_ready <= !stall && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // long receiver hold-off while the sender keeps offering
   initial begin
      wait (start_hold);
      @(posedge clock);
      stall <= 1'b1;
      repeat (600) @(posedge clock);
      stall <= 1'b0;
   end

   task automatic wait_idle();
      while (pixel_queue.size() > 0 || req_valid || orient_queue.size() > 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, int val);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(val);
      case (idx)
         CSR_FRAME_WIDTH:  cfg_width = val & 'h7FF;
         CSR_FRAME_HEIGHT: cfg_height = val & 'h1FFF;
         default:          cfg_gain = val & 'hFFFF;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic push_pixel(logic fs);
      req_type p;
      p.frame_start = fs;
      if ($urandom_range(3) == 0) begin
         p.red = $urandom_range(1) ? 8'hFF : 8'h00;
         p.green = $urandom_range(1) ? 8'hFF : 8'h00;
         p.blue = $urandom_range(1) ? 8'hFF : 8'h00;
      end else begin
         p.red = $urandom;
         p.green = $urandom;
         p.blue = $urandom;
      end
      pixel_queue.push_back(p);
   endtask

   initial begin
      int sent;
      int w;
      int hh;
      int n;
      req_type p;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      tx_idle_pct = 20;
      rx_idle_pct = 85;

      // directed: extremes on a 5 x 4 frame
      write_csr(CSR_FRAME_WIDTH, 5);
      write_csr(CSR_FRAME_HEIGHT, 4);
      write_csr(CSR_VALUE_GAIN, 256);
      for (int i = 0; i < 20; i++) begin
         p.frame_start = (i == 0);
         p.red = (i % 3 == 0) ? 8'hFF : 8'h00;
         p.green = (i % 2 == 0) ? 8'hFF : 8'h00;
         p.blue = (i % 5 == 1) ? 8'hFF : 8'h00;
         pixel_queue.push_back(p);
      end
      wait_idle();

      // lower the width in mid-frame
      write_csr(CSR_FRAME_WIDTH, 16);
      write_csr(CSR_FRAME_HEIGHT, 6);
      write_csr(CSR_VALUE_GAIN, 0);
      push_pixel(1'b1);
      for (int i = 1; i < 40; i++) push_pixel(1'b0);
      wait_idle();
      write_csr(CSR_FRAME_WIDTH, 5);
      write_csr(CSR_VALUE_GAIN, 65535);
      for (int i = 0; i < 30; i++) push_pixel(1'b0);
      wait_idle();

      // sizes below range, frame wrap without frame_start
      write_csr(CSR_FRAME_WIDTH, 0);
      write_csr(CSR_FRAME_HEIGHT, 0);
      push_pixel(1'b1);
      for (int i = 1; i < 20; i++) push_pixel(1'b0);
      wait_idle();

      // width above range, start of a row
      write_csr(CSR_FRAME_WIDTH, 2047);
      write_csr(CSR_FRAME_HEIGHT, 3);
      write_csr(CSR_VALUE_GAIN, 255);
      push_pixel(1'b1);
      for (int i = 1; i < 40; i++) push_pixel(1'b0);
      wait_idle();

      // tallest setting, partial frame
      write_csr(CSR_FRAME_WIDTH, 4);
      write_csr(CSR_FRAME_HEIGHT, 8191);
      push_pixel(1'b1);
      for (int i = 1; i < 30; i++) push_pixel(1'b0);
      wait_idle();

      // random frames
      sent = 0;
      while (sent < 470) begin
         if (sent < 160) begin
            tx_idle_pct = 20;
            rx_idle_pct = 85;
         end else if (sent < 320) begin
            tx_idle_pct = 85;
            rx_idle_pct = 20;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         w = $urandom_range(12, 3);
         hh = $urandom_range(9, 3);
         write_csr(CSR_FRAME_WIDTH, w);
         write_csr(CSR_FRAME_HEIGHT, hh);
         case ($urandom_range(4))
            0: write_csr(CSR_VALUE_GAIN, 0);
            1: write_csr(CSR_VALUE_GAIN, 65535);
            2: write_csr(CSR_VALUE_GAIN, 256);
            default: write_csr(CSR_VALUE_GAIN, $urandom_range(65535));
         endcase
         if (sent == 0) begin
            for (int i = 0; i < 150; i++) push_pixel(i % (w*hh) == 0);
            sent += 150;
            start_hold = 1'b1;
         end else begin
            for (int f = 0; f < $urandom_range(3, 1); f++) begin
               n = ($urandom_range(5) == 0) ? $urandom_range(w*hh) : w*hh;
               for (int i = 0; i < n; i++)
                  push_pixel((i == 0 && $urandom_range(9) != 0) || $urandom_range(59) == 0);
               sent += n;
            end
         end
         wait_idle();
      end

      wait_idle();
      repeat (60) @(posedge clock);
      if (errors == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

FILE: sim.f
design/gohsv_pkg.sv
design/gradient_orientation_hsv.sv
bench/tb.sv
